// ===== rtl/rcsp_pkg.sv =====
`timescale 1ns / 1ps
package rcsp_pkg;
   localparam int MAX_SLOTS_DEF = 128;

   localparam logic [30:0] SLOT_BYTES_RST = 31'd33554432;
   localparam logic [7:0] SLOTS_RST = 8'd128;

   localparam logic [15:0] ST_FREE = 16'd0;
   localparam logic [15:0] ST_WRITING = 16'd1;
   localparam logic [15:0] ST_READY = 16'd2;
   localparam logic [15:0] ST_MAX = 16'hFFFF;

   localparam int HEADER_BYTES = 48;
   localparam int STATE_BYTES = 4;
   localparam int ALIGN_BYTES = 64;

   typedef enum logic [1:0] {
      OP_ACQUIRE = 2'd0,
      OP_MARK_READY = 2'd1,
      OP_ADD_REF = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0,
      ERR_NO_FREE = 3'd1,
      ERR_BAD_SIZE = 3'd2,
      ERR_BAD_ID = 3'd3,
      ERR_NOT_READY = 3'd4
   } err_type;

   typedef enum logic [0:0] {
      REG_SLOT_BYTES = 1'b0,
      REG_SLOTS_IN_USE = 1'b1
   } reg_type;

   typedef struct packed {
      op_type op;
      logic apply;
   } cell_cmd_type;

   typedef struct packed {
      logic ok;
      logic bad;
      logic ready;
   } cell_rsp_type;
endpackage

// ===== rtl/rcsp_req_if.sv =====
`timescale 1ns / 1ps
interface rcsp_req_if;
   logic valid;
   logic ready;
   logic [1:0] operation;
   logic [6:0] slot_id;
   logic [30:0] byte_count;

   modport source (output valid, output operation, output slot_id, output byte_count,
                   input ready);
   modport sink (input valid, input operation, input slot_id, input byte_count,
                 output ready);
endinterface

// ===== rtl/rcsp_rsp_if.sv =====
`timescale 1ns / 1ps
interface rcsp_rsp_if;
   logic valid;
   logic ready;
   logic ok;
   logic [2:0] error_code;
   logic [6:0] granted_slot;
   logic [36:0] slot_address;
   logic ready_res;

   modport source (output valid, output ok, output error_code, output granted_slot,
                   output slot_address, output ready_res, input ready);
   modport sink (input valid, input ok, input error_code, input granted_slot,
                 input slot_address, input ready_res, output ready);
endinterface

// ===== rtl/rcsp_cell.sv =====
`timescale 1ns / 1ps
module rcsp_cell (
   input  logic clock,
   input  logic reset,
   input  rcsp_pkg::cell_cmd_type cmd,
   input  logic sel,
   input  logic tok_in,
   input  logic inject,
   input  logic advance,
   input  logic kill,
   output logic tok_pass,
   output logic claim,
   output rcsp_pkg::cell_rsp_type rsp
);
   logic [15:0] state_ff, state_in, upd;
   logic tok_ff, tok_in_nxt;
   logic is_free, ok, bad;

   assign is_free = (state_ff == rcsp_pkg::ST_FREE);
   assign claim = tok_ff && is_free && advance;
   assign tok_pass = tok_ff && !is_free;

   always_comb begin
      ok = 1'b0;
      bad = 1'b0;
      upd = state_ff;
      case (cmd.op)
         rcsp_pkg::OP_MARK_READY: begin
            upd = rcsp_pkg::ST_READY;
            ok = 1'b1;
         end
         rcsp_pkg::OP_ADD_REF: begin
            if (state_ff < rcsp_pkg::ST_READY || state_ff == rcsp_pkg::ST_MAX) begin
               bad = 1'b1;
            end else begin
               upd = state_ff + 16'd1;
               ok = 1'b1;
            end
         end
         rcsp_pkg::OP_RELEASE: begin
            if (state_ff < rcsp_pkg::ST_READY) begin
               bad = 1'b1;
            end else begin
               upd = (state_ff == rcsp_pkg::ST_READY) ? rcsp_pkg::ST_FREE : state_ff - 16'd1;
               ok = 1'b1;
            end
         end
         default: begin
            upd = state_ff;
         end
      endcase
   end

   assign rsp.ok = sel && ok;
   assign rsp.bad = sel && bad;
   assign rsp.ready = sel && (upd >= rcsp_pkg::ST_READY);

   always_comb begin
      state_in = state_ff;
      if (claim) begin
         state_in = rcsp_pkg::ST_WRITING;
      end else if (sel && cmd.apply) begin
         state_in = upd;
      end
      tok_in_nxt = advance ? (tok_in && !kill) : tok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcsp_pkg::ST_FREE;
         tok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tok_ff <= inject || tok_in_nxt;
      end
   end
endmodule

// ===== rtl/refcounted_slot_pool_unit.sv =====
`timescale 1ns / 1ps
// Reference-counted slot pool.
// req_ch carries one command per transfer: acquire, mark ready, add reference
// or release. rsp_ch returns exactly one result per command, in order.
// csr_we/csr_index/csr_wdata write slot_bytes (index 0) and slots_in_use
// (index 1); write only while no command is in flight.
// Each slot's state lives in its own cell of a ring of MAX_SLOTS cells. An
// acquire reduces the rotating start pointer modulo the slot count by
// repeated subtraction (one step a cycle, up to start/n steps), then hands a
// search token from cell to cell, one cell per cycle, until a free slot
// claims it or all n slots were visited.
// Mark ready, add reference, release and an acquire that fails its checks
// pass from S_IDLE through S_MOD and S_EXEC to the result register; other
// acquires also step in S_MOD and then let the token visit k cells (1..n).
// One command is in work at a time; the next is taken once the previous
// result is registered, also while that result still waits on rsp_ch.
// A stalled receiver holds the result register and freezes the token ring.
// Reset is synchronous: all slots free, start pointer zero, the CSRs at
// their reset values. No clearing pass is needed.
module refcounted_slot_pool_unit #(
   parameter int MAX_SLOTS = rcsp_pkg::MAX_SLOTS_DEF
) (
   input  logic clock,
   input  logic reset,
   rcsp_req_if.sink req_ch,
   rcsp_rsp_if.source rsp_ch,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [30:0] csr_wdata
);
   localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int NW = $clog2(MAX_SLOTS + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MOD = 4'b0010,
      S_EXEC = 4'b0100,
      S_SCAN = 4'b1000
   } fsm_type;

   fsm_type state_ff, state_in;
   logic [30:0] slot_bytes_ff;
   logic [7:0] slots_ff;
   logic [IW-1:0] start_ff, start_in;
   logic [NW-1:0] steps_ff, steps_in;
   logic [1:0] op_ff;
   logic [6:0] id_ff;
   logic [30:0] bytes_ff;
   logic [NW-1:0] n_eff;

   logic rsp_valid_ff, rsp_ok_ff, rsp_ready_res_ff;
   logic [2:0] rsp_err_ff;
   logic [6:0] rsp_slot_ff;
   logic [36:0] rsp_addr_ff;

   logic out_free, wr_out, wr_ok, wr_rdy;
   logic [2:0] wr_err;
   logic [6:0] wr_slot;
   logic [36:0] wr_addr;

   rcsp_pkg::cell_cmd_type cmd;
   rcsp_pkg::cell_rsp_type [MAX_SLOTS-1:0] crsp;
   logic [MAX_SLOTS-1:0] sel, tok_in, inject, tok_pass, claim;
   logic advance, kill, inj_en, found, id_ok;
   logic [IW-1:0] found_id;
   logic any_ok, any_bad, any_rdy;
   logic [9:0] hdr;
   logic [37:0] prod;

   assign n_eff = (32'(slots_ff) > 32'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : NW'(slots_ff);
   assign id_ok = 32'(id_ff) < 32'(n_eff);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   assign cmd.op = rcsp_pkg::op_type'(op_ff);
   assign cmd.apply = (state_ff == S_EXEC) && out_free &&
                      (op_ff != rcsp_pkg::OP_ACQUIRE) && id_ok;

   genvar g;
   generate
      for (g = 0; g < MAX_SLOTS; g++) begin : g_cell
         assign sel[g] = (32'(id_ff) == g);
         assign inject[g] = inj_en && (32'(start_ff) == g);
         if (g == 0) begin : g_wrap
            assign tok_in[g] = |(tok_pass & (MAX_SLOTS'(1) << (n_eff - NW'(1))));
         end else begin : g_link
            assign tok_in[g] = tok_pass[g-1] && (32'(n_eff) != g);
         end
         rcsp_cell u_cell (
            .clock(clock), .reset(reset), .cmd(cmd), .sel(sel[g]),
            .tok_in(tok_in[g]), .inject(inject[g]), .advance(advance), .kill(kill),
            .tok_pass(tok_pass[g]), .claim(claim[g]), .rsp(crsp[g])
         );
      end
   endgenerate

   always_comb begin
      found_id = '0;
      any_ok = 1'b0;
      any_bad = 1'b0;
      any_rdy = 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (claim[i]) found_id = found_id | IW'(i);
         any_ok = any_ok | crsp[i].ok;
         any_bad = any_bad | crsp[i].bad;
         any_rdy = any_rdy | crsp[i].ready;
      end
   end
   assign found = |claim;

   assign hdr = ((10'(rcsp_pkg::HEADER_BYTES) + {n_eff, 2'b00} + 10'(rcsp_pkg::ALIGN_BYTES - 1))
                 >> 6) << 6;
   assign prod = 38'(found_id) * 38'(slot_bytes_ff);

   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      steps_in = steps_ff;
      advance = 1'b0;
      kill = 1'b0;
      inj_en = 1'b0;
      wr_out = 1'b0;
      wr_ok = 1'b0;
      wr_err = rcsp_pkg::ERR_NONE;
      wr_slot = '0;
      wr_addr = '0;
      wr_rdy = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) state_in = S_MOD;
         end
         S_MOD: begin
            if (op_ff == rcsp_pkg::OP_ACQUIRE && bytes_ff != '0 &&
                bytes_ff <= slot_bytes_ff && n_eff != '0 &&
                32'(start_ff) >= 32'(n_eff)) begin
               start_in = start_ff - IW'(n_eff);
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               wr_out = 1'b1;
               state_in = S_IDLE;
               if (op_ff != rcsp_pkg::OP_ACQUIRE) begin
                  if (!id_ok) begin
                     wr_err = rcsp_pkg::ERR_BAD_ID;
                  end else begin
                     wr_ok = any_ok;
                     wr_err = any_bad ? rcsp_pkg::ERR_NOT_READY : rcsp_pkg::ERR_NONE;
                     wr_rdy = any_rdy;
                  end
               end else if (bytes_ff == '0 || bytes_ff > slot_bytes_ff) begin
                  wr_err = rcsp_pkg::ERR_BAD_SIZE;
               end else if (n_eff == '0) begin
                  wr_err = rcsp_pkg::ERR_NO_FREE;
               end else begin
                  wr_out = 1'b0;
                  inj_en = 1'b1;
                  steps_in = n_eff;
                  start_in = (32'(start_ff) + 1 == 32'(n_eff)) ? '0 : start_ff + IW'(1);
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (out_free) begin
               advance = 1'b1;
               steps_in = steps_ff - NW'(1);
               if (found) begin
                  wr_out = 1'b1;
                  wr_ok = 1'b1;
                  wr_slot = 7'(found_id);
                  wr_addr = 37'(prod) + 37'(hdr);
                  state_in = S_IDLE;
               end else if (steps_ff == NW'(1)) begin
                  kill = 1'b1;
                  wr_out = 1'b1;
                  wr_err = rcsp_pkg::ERR_NO_FREE;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= '0;
         steps_ff <= '0;
         rsp_valid_ff <= 1'b0;
         slot_bytes_ff <= rcsp_pkg::SLOT_BYTES_RST;
         slots_ff <= rcsp_pkg::SLOTS_RST;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         steps_ff <= steps_in;
         if (wr_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            if (csr_index == rcsp_pkg::REG_SLOT_BYTES) begin
               slot_bytes_ff <= csr_wdata;
            end else begin
               slots_ff <= csr_wdata[7:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_ch.valid) begin
         op_ff <= req_ch.operation;
         id_ff <= req_ch.slot_id;
         bytes_ff <= req_ch.byte_count;
      end
      if (wr_out) begin
         rsp_ok_ff <= wr_ok;
         rsp_err_ff <= wr_err;
         rsp_slot_ff <= wr_slot;
         rsp_addr_ff <= wr_addr;
         rsp_ready_res_ff <= wr_rdy;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.ok = rsp_ok_ff;
   assign rsp_ch.error_code = rsp_err_ff;
   assign rsp_ch.granted_slot = rsp_slot_ff;
   assign rsp_ch.slot_address = rsp_addr_ff;
   assign rsp_ch.ready_res = rsp_ready_res_ff;
endmodule
